// File: design/law_pkg.sv
`default_nettype none
package law_pkg;
   localparam int MaxLen = 32;
   localparam int IdxW = 5;
   localparam int LenW = 6;
   localparam int ScoreW = 9;
   localparam int BufDepth = 2 * MaxLen;
   localparam int BufW = 6;

   typedef enum logic [1:0] {
      CMD_LOAD_A = 2'd0,
      CMD_LOAD_B = 2'd1,
      CMD_ALIGN  = 2'd2,
      CMD_NONE   = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      PTR_SELF = 2'd0,
      PTR_DIAG = 2'd1,
      PTR_UP   = 2'd2,
      PTR_LEFT = 2'd3
   } pointer_type;

   localparam logic [1:0] REG_MATCH = 2'd0;
   localparam logic [1:0] REG_MISMATCH = 2'd1;
   localparam logic [1:0] REG_GAP = 2'd2;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] symbol;
      logic       final_symbol;
   } req_type;

   typedef struct packed {
      logic [7:0] row_symbol;
      logic       row_gap;
      logic [7:0] col_symbol;
      logic       col_gap;
      logic [8:0] best_score;
      logic       empty_alignment;
      logic       last_column;
   } rsp_type;
endpackage
`default_nettype wire

// File: design/local_alignment_traceback_top.sv
`default_nettype none
// Smith-Waterman local alignment with linear gap and traceback.
// The req channel carries one beat per command: load a byte of A, load a
// byte of B, or align. Load beats are taken one per cycle while the block
// is idle and holds no rsp beat, and give no result. An align beat holds
// req_ready low while one shared score unit sweeps the grid one cell per
// cycle. The ST_TRACE_INIT state then sets up the traceback, which walks
// the pointer memory from the best cell, reading a column in ST_TRACE_RD
// and taking it in ST_TRACE. The columns then leave on the rsp channel
// start first, the last one flagged by last_column. An empty alignment
// gives a single beat with empty_alignment set when a sequence is empty,
// or after the sweep and ST_TRACE_INIT when no cell scores above zero.
// The csr channel writes the match, mismatch and gap scores; it is always
// ready; the user must use it only while the block is idle (not enforced).
// When the receiver stalls, the held rsp beat stays unchanged and the
// sequencer waits. The next req beat is taken once the last rsp beat is gone.
// Reset is synchronous and restores the default scores, empty sequences and
// the idle state; the memories are not cleared.
module local_alignment_traceback_top
   import law_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [4:0]  csr_data
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_FILL, ST_TRACE_INIT, ST_TRACE_RD, ST_TRACE, ST_EMIT_RD, ST_EMIT,
      ST_EMPTY
   } state_type;

   state_type state_ff;
   logic signed [4:0] match_ff, mismatch_ff, gap_ff;
   logic [7:0] row_mem [MaxLen];
   logic [7:0] col_mem [MaxLen];
   logic [1:0] ptr_mem [MaxLen * MaxLen];
   logic [17:0] buf_mem [BufDepth];
   logic [ScoreW-1:0] score_ff [MaxLen];
   logic [LenW-1:0] row_len_ff, col_len_ff;
   logic row_sealed_ff, col_sealed_ff;
   logic [LenW-1:0] i_ff, j_ff;
   logic [ScoreW-1:0] diag_ff, best_ff;
   logic [LenW-1:0] bi_ff, bj_ff;
   logic [BufW:0] n_ff, k_ff;
   logic [1:0] ptr_rd_ff;
   logic [7:0] a_rd_ff, b_rd_ff;
   logic [17:0] buf_rd_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   logic [IdxW-1:0] ci, cj;
   logic [ScoreW-1:0] up_c, left_c;
   logic signed [11:0] cand_d, cand_u, cand_l, best_c;
   pointer_type ptr_c;
   logic [ScoreW-1:0] best_sat;
   logic [IdxW-1:0] ti, tj;

   assign ci = IdxW'(i_ff - LenW'(1));
   assign cj = IdxW'(j_ff - LenW'(1));
   assign ti = IdxW'(i_ff - LenW'(1));
   assign tj = IdxW'(j_ff - LenW'(1));

   // The first row and the first column see the zero boundary.
   assign up_c = (i_ff == LenW'(1)) ? '0 : score_ff[cj];
   assign left_c = (j_ff == LenW'(1)) ? '0 : score_ff[cj - IdxW'(1)];

   always_comb begin
      cand_d = $signed({3'b000, diag_ff}) +
               ((row_mem[ci] == col_mem[cj]) ? 12'(match_ff) : 12'(mismatch_ff));
      cand_u = $signed({3'b000, up_c}) + 12'(gap_ff);
      cand_l = $signed({3'b000, left_c}) + 12'(gap_ff);
      best_c = '0;
      ptr_c = PTR_SELF;
      if (cand_d > best_c) begin
         best_c = cand_d;
         ptr_c = PTR_DIAG;
      end
      if (cand_u > best_c) begin
         best_c = cand_u;
         ptr_c = PTR_UP;
      end
      if (cand_l > best_c) begin
         best_c = cand_l;
         ptr_c = PTR_LEFT;
      end
      best_sat = (best_c > 12'sd511) ? 9'd511 : best_c[ScoreW-1:0];
   end

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_FILL) begin
         ptr_mem[{ci, cj}] <= ptr_c;
         score_ff[cj] <= best_sat;
      end
      ptr_rd_ff <= ptr_mem[{ti, tj}];
      a_rd_ff <= row_mem[ti];
      b_rd_ff <= col_mem[tj];
      buf_rd_ff <= buf_mem[BufW'(n_ff - k_ff - (BufW + 1)'(1))];
      if (state_ff == ST_TRACE && ptr_rd_ff != PTR_SELF) begin
         buf_mem[n_ff[BufW-1:0]] <= {
            (ptr_rd_ff == PTR_LEFT) ? 8'd0 : a_rd_ff, ptr_rd_ff == PTR_LEFT,
            (ptr_rd_ff == PTR_UP) ? 8'd0 : b_rd_ff, ptr_rd_ff == PTR_UP};
      end
      if (req_valid && req_ready && req_data.command == CMD_LOAD_A) begin
         if (row_sealed_ff) begin
            row_mem[0] <= req_data.symbol;
         end else if (row_len_ff < LenW'(MaxLen)) begin
            row_mem[row_len_ff[IdxW-1:0]] <= req_data.symbol;
         end
      end
      if (req_valid && req_ready && req_data.command == CMD_LOAD_B) begin
         if (col_sealed_ff) begin
            col_mem[0] <= req_data.symbol;
         end else if (col_len_ff < LenW'(MaxLen)) begin
            col_mem[col_len_ff[IdxW-1:0]] <= req_data.symbol;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         match_ff <= 5'sd2;
         mismatch_ff <= -5'sd1;
         gap_ff <= -5'sd1;
         row_len_ff <= '0;
         col_len_ff <= '0;
         row_sealed_ff <= 1'b1;
         col_sealed_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            unique case (csr_index)
               REG_MATCH: match_ff <= csr_data;
               REG_MISMATCH: mismatch_ff <= csr_data;
               REG_GAP: gap_ff <= csr_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready) begin
                  unique case (req_data.command)
                     CMD_LOAD_A: begin
                        if (row_sealed_ff) begin
                           row_len_ff <= LenW'(1);
                        end else if (row_len_ff < LenW'(MaxLen)) begin
                           row_len_ff <= row_len_ff + LenW'(1);
                        end
                        row_sealed_ff <= req_data.final_symbol;
                     end
                     CMD_LOAD_B: begin
                        if (col_sealed_ff) begin
                           col_len_ff <= LenW'(1);
                        end else if (col_len_ff < LenW'(MaxLen)) begin
                           col_len_ff <= col_len_ff + LenW'(1);
                        end
                        col_sealed_ff <= req_data.final_symbol;
                     end
                     CMD_ALIGN: begin
                        best_ff <= '0;
                        bi_ff <= '0;
                        bj_ff <= '0;
                        i_ff <= LenW'(1);
                        j_ff <= LenW'(1);
                        diag_ff <= '0;
                        state_ff <= (row_len_ff == '0 || col_len_ff == '0) ?
                                    ST_EMPTY : ST_FILL;
                     end
                     default: ;
                  endcase
               end
            end
            ST_FILL: begin
               if (best_sat > best_ff) begin
                  best_ff <= best_sat;
                  bi_ff <= i_ff;
                  bj_ff <= j_ff;
               end
               if (j_ff == col_len_ff) begin
                  j_ff <= LenW'(1);
                  diag_ff <= '0;
                  if (i_ff == row_len_ff) begin
                     state_ff <= ST_TRACE_INIT;
                  end else begin
                     i_ff <= i_ff + LenW'(1);
                  end
               end else begin
                  j_ff <= j_ff + LenW'(1);
                  diag_ff <= up_c;
               end
            end
            ST_TRACE_INIT: begin
               i_ff <= bi_ff;
               j_ff <= bj_ff;
               n_ff <= '0;
               state_ff <= (best_ff == '0) ? ST_EMPTY : ST_TRACE_RD;
            end
            ST_TRACE_RD: begin
               state_ff <= ST_TRACE;
            end
            ST_TRACE: begin
               if (ptr_rd_ff == PTR_SELF) begin
                  state_ff <= (n_ff == '0) ? ST_EMPTY : ST_EMIT_RD;
                  k_ff <= '0;
               end else begin
                  logic [LenW-1:0] ni, nj;
                  ni = (ptr_rd_ff != PTR_LEFT) ? i_ff - LenW'(1) : i_ff;
                  nj = (ptr_rd_ff != PTR_UP) ? j_ff - LenW'(1) : j_ff;
                  n_ff <= n_ff + (BufW + 1)'(1);
                  i_ff <= ni;
                  j_ff <= nj;
                  k_ff <= '0;
                  if (ni == '0 || nj == '0 ||
                      n_ff + (BufW + 1)'(1) == (BufW + 1)'(BufDepth)) begin
                     state_ff <= ST_EMIT_RD;
                  end else begin
                     state_ff <= ST_TRACE_RD;
                  end
               end
            end
            ST_EMIT_RD: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff.row_symbol <= buf_rd_ff[17:10];
               rsp_ff.row_gap <= buf_rd_ff[9];
               rsp_ff.col_symbol <= buf_rd_ff[8:1];
               rsp_ff.col_gap <= buf_rd_ff[0];
               rsp_ff.best_score <= best_ff;
               rsp_ff.empty_alignment <= 1'b0;
               rsp_ff.last_column <= (k_ff + (BufW + 1)'(1) == n_ff);
               k_ff <= k_ff + (BufW + 1)'(1);
               state_ff <= (k_ff + (BufW + 1)'(1) == n_ff) ? ST_IDLE : ST_EMIT_RD;
            end
            ST_EMPTY: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff.row_symbol <= '0;
                  rsp_ff.row_gap <= 1'b0;
                  rsp_ff.col_symbol <= '0;
                  rsp_ff.col_gap <= 1'b0;
                  rsp_ff.best_score <= '0;
                  rsp_ff.empty_alignment <= 1'b1;
                  rsp_ff.last_column <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
